FILE: rtl/framed_command_reply_engine_top_macros.svh
// assertion macros used by the engine sequencer
`ifndef FRAMED_COMMAND_REPLY_ENGINE_TOP_MACROS_SVH
`define FRAMED_COMMAND_REPLY_ENGINE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define FECR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FECR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fecr_pkg.sv
// shared types and constants of the framed command reply engine
`timescale 1ns / 1ps

package fecr_pkg;

  localparam int unsigned MAX_LEN_DEF = 32;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  START_MARK  = 8'hAA;

  // request kinds on the input tuser
  localparam logic [1:0] REQ_HOST = 2'd0;
  localparam logic [1:0] REQ_LINK = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // result kinds on the output tuser
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_RX   = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_CORRUPT  = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] code;
    logic       last;
  } beat_t;

endpackage

FILE: rtl/fecr_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fecr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fecr_out.sv
// output register stage of the result stream
`timescale 1ns / 1ps

module fecr_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fecr_pkg::beat_t   beat,
  output logic              rdy,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // out_byte, status_code, zero fill
  output logic [1:0]        m_axis_tuser,  // out_kind
  output logic              m_axis_tlast
);

  fecr_pkg::beat_t beat_r;
  logic            vld;

  assign rdy = !vld || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rdy) begin
      vld <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && rdy) begin
      beat_r <= beat;
    end
  end

  assign m_axis_tvalid = vld;
  assign m_axis_tdata  = {5'd0, beat_r.code, beat_r.data};
  assign m_axis_tuser  = beat_r.kind;
  assign m_axis_tlast  = beat_r.last;

endmodule

FILE: rtl/fecr_seq.sv
// transaction control and burst sequencer around the payload ram
`timescale 1ns / 1ps
`include "framed_command_reply_engine_top_macros.svh"

module fecr_seq #(
  parameter int unsigned MAX_LEN = fecr_pkg::MAX_LEN_DEF,
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic [1:0]      s_tuser,
  input  logic            s_tlast,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data,
  output logic            push,
  output fecr_pkg::beat_t beat,
  input  logic            out_rdy,
  output logic            we,
  output logic [AW-1:0]   waddr,
  output logic [7:0]      wdata,
  output logic            re,
  output logic [AW-1:0]   raddr,
  input  logic [7:0]      rdata
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [6:0] {
    S_ACC  = 7'b0000001,
    S_HEAD = 7'b0000010,
    S_LEN  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_BYTE = 7'b0010000,
    S_TAIL = 7'b0100000,
    S_ONE  = 7'b1000000
  } seq_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HUNT = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_SUM  = 5'b10000
  } ph_t;

  seq_t          state, state_next;
  ph_t           phase, phase_next;
  logic [CW-1:0] bc, bc_next;
  logic [CW-1:0] idx, idx_next;
  logic [7:0]    flen, flen_next;
  logic [7:0]    sum, sum_next;
  logic [15:0]   ticks, ticks_next;
  logic          too_long, too_long_next;
  logic          reply, reply_next;
  logic [2:0]    code, code_next;
  logic [15:0]   timeout;

  logic          acc;
  logic [CW-1:0] bc_inc;
  logic          room;
  logic [CW-1:0] bc_host;
  logic          tl_host;

  assign s_tready  = (state == S_ACC);
  assign acc       = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign bc_inc    = bc + CW'(1);
  assign room      = (bc < CW'(MAX_LEN));
  assign bc_host   = room ? bc_inc : bc;
  assign tl_host   = too_long || !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= fecr_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      timeout <= cfg_data;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    bc_next       = bc;
    idx_next      = idx;
    flen_next     = flen;
    sum_next      = sum;
    ticks_next    = ticks;
    too_long_next = too_long;
    reply_next    = reply;
    code_next     = code;
    push          = 1'b0;
    beat          = '0;
    we            = 1'b0;
    waddr         = bc[AW-1:0];
    wdata         = s_tdata;
    re            = 1'b0;
    raddr         = idx[AW-1:0];

    unique case (state)
      S_ACC: begin
        if (acc) begin
          case (s_tuser)
            fecr_pkg::REQ_HOST: begin
              if (phase != PH_IDLE) begin
                code_next  = fecr_pkg::ST_BUSY;
                state_next = S_ONE;
              end else begin
                we = room;
                if (!s_tlast) begin
                  bc_next       = bc_host;
                  too_long_next = tl_host;
                end else if (tl_host) begin
                  code_next     = fecr_pkg::ST_OVERFLOW;
                  state_next    = S_ONE;
                  bc_next       = '0;
                  too_long_next = 1'b0;
                end else begin
                  flen_next  = 8'(bc_host);
                  sum_next   = fecr_pkg::START_MARK + 8'(bc_host);
                  bc_next    = '0;
                  ticks_next = timeout;
                  phase_next = PH_HUNT;
                  idx_next   = '0;
                  reply_next = 1'b0;
                  state_next = S_HEAD;
                end
              end
            end
            fecr_pkg::REQ_LINK: begin
              unique case (phase)
                PH_HUNT: begin
                  if (s_tdata == fecr_pkg::START_MARK) begin
                    sum_next   = fecr_pkg::START_MARK;
                    phase_next = PH_LEN;
                  end
                end
                PH_LEN: begin
                  flen_next = s_tdata;
                  sum_next  = sum + s_tdata;
                  bc_next   = '0;
                  if (s_tdata > 8'(MAX_LEN)) begin
                    code_next     = fecr_pkg::ST_OVERFLOW;
                    state_next    = S_ONE;
                    phase_next    = PH_IDLE;
                    too_long_next = 1'b0;
                  end else if (s_tdata == 8'd0) begin
                    phase_next = PH_SUM;
                  end else begin
                    phase_next = PH_DATA;
                  end
                end
                PH_DATA: begin
                  we       = 1'b1;
                  bc_next  = bc_inc;
                  sum_next = sum + s_tdata;
                  if (8'(bc_inc) >= flen) begin
                    phase_next = PH_SUM;
                  end
                end
                PH_SUM: begin
                  if (s_tdata == sum) begin
                    reply_next = 1'b1;
                    idx_next   = '0;
                    state_next = S_RD;
                  end else begin
                    code_next  = fecr_pkg::ST_CORRUPT;
                    state_next = S_ONE;
                  end
                  phase_next    = PH_IDLE;
                  bc_next       = '0;
                  too_long_next = 1'b0;
                end
                default: begin
                end
              endcase
            end
            fecr_pkg::REQ_TICK: begin
              if (phase != PH_IDLE) begin
                if (ticks <= 16'd1) begin
                  ticks_next    = '0;
                  code_next     = fecr_pkg::ST_TIMEOUT;
                  state_next    = S_ONE;
                  phase_next    = PH_IDLE;
                  bc_next       = '0;
                  too_long_next = 1'b0;
                end else begin
                  ticks_next = ticks - 16'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_HEAD: begin
        beat = '{kind: fecr_pkg::KIND_TX, data: fecr_pkg::START_MARK,
                 code: fecr_pkg::ST_OK, last: 1'b0};
        push = out_rdy;
        if (out_rdy) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        beat = '{kind: fecr_pkg::KIND_TX, data: flen, code: fecr_pkg::ST_OK, last: 1'b0};
        push = out_rdy;
        if (out_rdy) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (8'(idx) == flen) begin
          state_next = S_TAIL;
        end else begin
          re         = 1'b1;
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        beat = '{kind: reply ? fecr_pkg::KIND_RX : fecr_pkg::KIND_TX, data: rdata,
                 code: fecr_pkg::ST_OK, last: 1'b0};
        push = out_rdy;
        if (out_rdy) begin
          idx_next   = idx + CW'(1);
          sum_next   = sum + rdata;
          state_next = S_RD;
        end
      end
      S_TAIL: begin
        if (reply) begin
          beat = '{kind: fecr_pkg::KIND_STAT, data: 8'd0, code: fecr_pkg::ST_OK, last: 1'b1};
        end else begin
          beat = '{kind: fecr_pkg::KIND_TX, data: sum, code: fecr_pkg::ST_OK, last: 1'b1};
        end
        push = out_rdy;
        if (out_rdy) begin
          state_next = S_ACC;
        end
      end
      S_ONE: begin
        beat = '{kind: fecr_pkg::KIND_STAT, data: 8'd0, code: code, last: 1'b1};
        push = out_rdy;
        if (out_rdy) begin
          state_next = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_ACC;
      phase    <= PH_IDLE;
      bc       <= '0;
      idx      <= '0;
      flen     <= '0;
      sum      <= '0;
      ticks    <= '0;
      too_long <= 1'b0;
      reply    <= 1'b0;
      code     <= fecr_pkg::ST_OK;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      bc       <= bc_next;
      idx      <= idx_next;
      flen     <= flen_next;
      sum      <= sum_next;
      ticks    <= ticks_next;
      too_long <= too_long_next;
      reply    <= reply_next;
      code     <= code_next;
    end
  end

  `FECR_ASSERT_IMP(a_bc_range, 1'b1, bc <= CW'(MAX_LEN), "byte count beyond buffer")
  `FECR_ASSERT_IMP(a_idx_range, state == S_BYTE, 8'(idx) < flen, "burst index past length")
  `FECR_ASSERT_IMP(a_byte_after_read, state == S_BYTE, $past(state) == S_RD || $past(state) == S_BYTE, "ram data used without read")
  `FECR_ASSERT_NXT(a_timeout, acc && s_tuser == fecr_pkg::REQ_TICK && phase != PH_IDLE && ticks <= 16'd1, state == S_ONE && phase == PH_IDLE && code == fecr_pkg::ST_TIMEOUT, "expired tick did not end transaction")

endmodule

FILE: rtl/framed_command_reply_engine_top.sv
// top level of the framed command reply engine
`timescale 1ns / 1ps

// Runs one command/reply transaction at a time over a byte link. Host command
// bytes (tuser 0) are buffered while idle; the beat with tlast sends the frame
// 0xAA, length, payload, 8-bit sum. Link bytes (tuser 1) are then parsed as a
// reply in the same framing, and timer ticks (tuser 2) count down the timeout
// loaded from the config register at frame start. Results come out as beats of
// kind 0 (link byte), 1 (reply payload byte) or 2 (status); tlast marks the last
// beat caused by one input beat. No new input beat is taken while the results
// of the last one are still being sent. Each payload byte of a frame or of a
// good reply is read from the payload ram and then handed to the output
// register, and output stalls hold the sequencer. Config writes are taken in
// any cycle and must only happen while no transaction is in progress.

module framed_command_reply_engine_top #(
  parameter int unsigned MAX_LEN = fecr_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic [1:0]  s_axis_tuser,   // req_type
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte, status_code, zero fill
  output logic [1:0]  m_axis_tuser,   // out_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  fecr_pkg::beat_t beat;
  logic            push;
  logic            out_rdy;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;

  fecr_seq #(
    .MAX_LEN(MAX_LEN)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .s_tlast  (s_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .push     (push),
    .beat     (beat),
    .out_rdy  (out_rdy),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  fecr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LEN)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  fecr_out u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .beat         (beat),
    .rdy          (out_rdy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

FILE: tb/tb.sv
// testbench for the framed command reply engine: directed and random exchanges checked against a predictor
`timescale 1ns / 1ps

module tb;
  import fecr_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [2:0] NO_CODE = 3'd0;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 48;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;

  typedef enum logic [2:0] {P_IDLE, P_HUNT, P_LEN, P_DATA, P_SUM} link_phase_e;

  class reply_scoreboard;
    logic [15:0] timeout_reg;
    link_phase_e ph;
    logic [7:0] payload [MAX_LEN_DEF];
    int unsigned fill;
    logic [7:0] flen;
    logic [7:0] rsum;
    logic [15:0] ticks_left;
    bit too_long;
    beat_t batch[$];
    beat_t waiting[$];
    int unsigned failures;
    int unsigned results_seen;
    int unsigned status_seen [5];

    function new();
      timeout_reg = TIMEOUT_RST;
      ph = P_IDLE;
      fill = 0;
      flen = 8'd0;
      rsum = 8'd0;
      ticks_left = 16'd0;
      too_long = 1'b0;
      failures = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void add(logic [1:0] kind, logic [7:0] data, logic [2:0] code);
      beat_t b;
      b.kind = kind;
      b.data = data;
      b.code = code;
      b.last = 1'b0;
      batch.push_back(b);
    endfunction

    function void go_idle();
      ph = P_IDLE;
      fill = 0;
      too_long = 1'b0;
    endfunction

    // returns 0 for beats the engine simply drops
    function bit take_request(logic [1:0] req, logic [7:0] data, logic lastb);
      bit active;
      logic [7:0] sum;
      batch.delete();
      active = 1'b1;
      case (req)
        REQ_HOST: begin
          if (ph != P_IDLE) begin
            add(KIND_STAT, 8'd0, ST_BUSY);
          end else begin
            if (fill < MAX_LEN_DEF) begin
              payload[fill] = data;
              fill++;
            end else begin
              too_long = 1'b1;
            end
            if (lastb) begin
              if (too_long) begin
                add(KIND_STAT, 8'd0, ST_OVERFLOW);
                go_idle();
              end else begin
                sum = START_MARK + 8'(fill);
                add(KIND_TX, START_MARK, NO_CODE);
                add(KIND_TX, 8'(fill), NO_CODE);
                for (int i = 0; i < fill; i++) begin
                  add(KIND_TX, payload[i], NO_CODE);
                  sum += payload[i];
                end
                add(KIND_TX, sum, NO_CODE);
                flen = 8'(fill);
                fill = 0;
                rsum = 8'd0;
                ticks_left = timeout_reg;
                ph = P_HUNT;
              end
            end
          end
        end
        REQ_LINK: begin
          case (ph)
            P_IDLE: active = 1'b0;
            P_HUNT: begin
              if (data == START_MARK) begin
                rsum = START_MARK;
                ph = P_LEN;
              end
            end
            P_LEN: begin
              flen = data;
              rsum += data;
              fill = 0;
              if (data > MAX_LEN_DEF) begin
                add(KIND_STAT, 8'd0, ST_OVERFLOW);
                go_idle();
              end else begin
                ph = (data == 8'd0) ? P_SUM : P_DATA;
              end
            end
            P_DATA: begin
              if (fill < MAX_LEN_DEF) payload[fill] = data;
              fill++;
              rsum += data;
              if (fill >= flen) ph = P_SUM;
            end
            default: begin
              if (data == rsum) begin
                for (int i = 0; i < flen; i++) add(KIND_RX, payload[i], NO_CODE);
                add(KIND_STAT, 8'd0, ST_OK);
              end else begin
                add(KIND_STAT, 8'd0, ST_CORRUPT);
              end
              go_idle();
            end
          endcase
        end
        REQ_TICK: begin
          if (ph == P_IDLE) begin
            active = 1'b0;
          end else if (ticks_left <= 16'd1) begin
            ticks_left = 16'd0;
            add(KIND_STAT, 8'd0, ST_TIMEOUT);
            go_idle();
          end else begin
            ticks_left--;
          end
        end
        default: active = 1'b0;
      endcase
      if (batch.size() > 0) begin
        batch[$].last = 1'b1;
        foreach (batch[i]) waiting.push_back(batch[i]);
      end
      return active;
    endfunction

    function void match_result(beat_t got, logic [4:0] fill_bits);
      beat_t exp;
      results_seen++;
      if (got.kind == KIND_STAT && got.code < 3'd5) status_seen[got.code]++;
      if (waiting.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: kind %0d byte %02h code %0d last %0b",
                   got.kind, got.data, got.code, got.last);
        return;
      end
      exp = waiting.pop_front();
      if (got.kind !== exp.kind || got.data !== exp.data || got.code !== exp.code ||
          got.last !== exp.last || fill_bits !== 5'd0) begin
        failures++;
        if (failures <= 10)
          $display("result mismatch: exp kind %0d byte %02h code %0d last %0b, got kind %0d byte %02h code %0d last %0b fill %02h",
                   exp.kind, exp.data, exp.code, exp.last,
                   got.kind, got.data, got.code, got.last, fill_bits);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // data_byte
  logic [1:0]  s_axis_tuser = 2'd0;   // req_type
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // out_byte, status_code, zero fill
  logic [1:0]  m_axis_tuser;          // out_kind
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  reply_scoreboard sb = new();
  beat_t seen_beat;
  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int items_done = 0;

  int phase_tx_idle [NUM_PHASES] = '{0, 51, 0, 12, 0, 0};
  int phase_rx_stall [NUM_PHASES] = '{0, 0, 51, 12, 0, 51};
  logic [15:0] phase_timeout [NUM_PHASES] = '{16'hFFFF, 16'd3, 16'd0, 16'd1, 16'd12, 16'd1000};

  framed_command_reply_engine_top u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_beat.kind = m_axis_tuser;
      seen_beat.data = m_axis_tdata[7:0];
      seen_beat.code = m_axis_tdata[10:8];
      seen_beat.last = m_axis_tlast;
      sb.match_result(seen_beat, m_axis_tdata[15:11]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", STALL_LIMIT);
      $display("framed_command_reply_engine_top verification failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] req, input logic [7:0] data, input logic lastb);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= data;
    s_axis_tlast <= lastb;
    do @(posedge clk); while (!s_axis_tready);
    if (sb.take_request(req, data, lastb)) items_done++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.waiting.size() != 0) @(posedge clk);
  endtask

  // ticks and stray host bytes dropped into a reply
  task automatic maybe_interject();
    int r;
    r = $urandom_range(99);
    if (r < 12)
      send_beat(REQ_TICK, 8'($urandom), 1'($urandom));
    else if (r < 17)
      send_beat(REQ_HOST, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_exchange();
    int len;
    int r;
    int noise;
    logic [7:0] b;
    logic [7:0] sum;
    if ($urandom_range(9) == 0) begin
      r = $urandom_range(2);
      send_beat((r == 0) ? REQ_TICK : (r == 1) ? REQ_LINK : REQ_NONE,
                8'($urandom), 1'($urandom));
    end
    r = $urandom_range(99);
    len = (r < 80) ? $urandom_range(1, 6) : (r < 92) ? $urandom_range(7, 32) :
          $urandom_range(33, 36);
    for (int i = 0; i < len; i++) send_beat(REQ_HOST, 8'($urandom), i == len - 1);
    if (sb.ph == P_IDLE) return;
    // no reply at all, ticks run out
    if (sb.timeout_reg <= 16'd20 && $urandom_range(9) < 2) begin
      while (sb.ph != P_IDLE) send_beat(REQ_TICK, 8'($urandom), 1'($urandom));
      return;
    end
    noise = $urandom_range(0, 2);
    for (int i = 0; i < noise; i++) begin
      b = 8'($urandom);
      if (b == START_MARK) b = 8'h55;
      send_beat(REQ_LINK, b, 1'($urandom));
      maybe_interject();
    end
    send_beat(REQ_LINK, START_MARK, 1'b0);
    maybe_interject();
    r = $urandom_range(99);
    len = (r < 85) ? $urandom_range(0, 6) : (r < 92) ? $urandom_range(7, 32) :
          $urandom_range(33, 255);
    send_beat(REQ_LINK, 8'(len), 1'($urandom));
    if (len > MAX_LEN_DEF) return;
    sum = START_MARK + 8'(len);
    for (int i = 0; i < len; i++) begin
      maybe_interject();
      b = 8'($urandom);
      sum += b;
      send_beat(REQ_LINK, b, 1'($urandom));
    end
    maybe_interject();
    if ($urandom_range(99) >= 85) sum ^= 8'($urandom_range(1, 255));
    send_beat(REQ_LINK, sum, 1'($urandom));
    if ($urandom_range(3) == 0) wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle drops, a busy host byte, then good, corrupt and oversized replies
    send_beat(REQ_TICK, 8'h00, 1'b0);
    send_beat(REQ_LINK, START_MARK, 1'b1);
    send_beat(REQ_NONE, 8'hFF, 1'b1);
    send_beat(REQ_HOST, 8'h00, 1'b0);
    send_beat(REQ_HOST, 8'hFF, 1'b1);
    send_beat(REQ_HOST, 8'h5A, 1'b1);
    send_beat(REQ_LINK, 8'h12, 1'b0);
    send_beat(REQ_LINK, START_MARK, 1'b0);
    send_beat(REQ_LINK, 8'h02, 1'b0);
    send_beat(REQ_LINK, 8'h00, 1'b0);
    send_beat(REQ_LINK, 8'hFF, 1'b0);
    send_beat(REQ_LINK, 8'hAB, 1'b0);
    send_beat(REQ_HOST, 8'h01, 1'b1);
    send_beat(REQ_LINK, START_MARK, 1'b0);
    send_beat(REQ_LINK, 8'h00, 1'b0);
    send_beat(REQ_LINK, 8'h00, 1'b0);
    send_beat(REQ_HOST, 8'h02, 1'b1);
    send_beat(REQ_LINK, START_MARK, 1'b0);
    send_beat(REQ_LINK, 8'd33, 1'b0);
    send_beat(REQ_HOST, 8'h03, 1'b1);
    send_beat(REQ_TICK, 8'h00, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // close any open exchange so the register is written while idle
      while (sb.ph != P_IDLE) begin
        case (sb.ph)
          P_HUNT: send_beat(REQ_LINK, START_MARK, 1'b0);
          P_LEN: send_beat(REQ_LINK, 8'd0, 1'b0);
          default: send_beat(REQ_LINK, 8'($urandom), 1'b0);
        endcase
      end
      wait_drained();
      repeat (10) @(posedge clk);
      send_idle_pct = phase_tx_idle[p];
      rx_stall_pct = phase_rx_stall[p];
      cfg_valid <= 1'b1;
      cfg_data <= phase_timeout[p];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      sb.timeout_reg = phase_timeout[p];
      if (p == 0) hold_left = HOLD_CYCLES;
      while (items_done < 21 + (p + 1) * PHASE_ITEMS) run_exchange();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.waiting.size() != 0) begin
      sb.failures += sb.waiting.size();
      $display("%0d expected result beats never arrived", sb.waiting.size());
    end
    $display("checked %0d result beats from %0d request beats over %0d timeout and flow settings",
             sb.results_seen, items_done, NUM_PHASES);
    $display("status beats: ok %0d busy %0d overflow %0d timeout %0d corrupt %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_BUSY], sb.status_seen[ST_OVERFLOW],
             sb.status_seen[ST_TIMEOUT], sb.status_seen[ST_CORRUPT]);
    if (sb.failures == 0) begin
      $display("framed_command_reply_engine_top verification clean");
    end else begin
      $display("%0d failures", sb.failures);
      $display("framed_command_reply_engine_top verification failed");
    end
    $finish;
  end

endmodule
